@@ src/gsks_pkg.sv @@
// Shared types and constants for the grouped sorted key search unit.
`default_nettype none

package gsks_pkg;

  localparam int unsigned GROUP_COUNT_DEF       = 8;
  localparam int unsigned ENTRIES_PER_GROUP_DEF = 256;
  localparam int unsigned KEY_LIMIT             = 4096;

  localparam int unsigned KEY_W   = 12;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned GROUP_W = 3;
  localparam int unsigned COUNT_W = 9;

  localparam logic [1:0] OP_WRITE     = 2'd0;
  localparam logic [1:0] OP_SET_COUNT = 2'd1;
  localparam logic [1:0] OP_SEARCH    = 2'd2;

  localparam logic [1:0] ST_FOUND   = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;
  localparam logic [1:0] ST_WRITTEN = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [GROUP_W-1:0] group;
    logic [POS_W-1:0]   position;
    logic [KEY_W-1:0]   key;
    logic [COUNT_W-1:0] entry_count;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [POS_W-1:0] match_position;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/grouped_sorted_key_search_unit.sv @@
// Grouped sorted key search unit: key table memory, count memory and search sequencer.
// A write, a set-count or an out-of-range item goes from IDLE straight to DONE; a search passes
// through CNT, then the PROBE state for each halving probe (none for an empty group, at most 9
// for 256 entries), then DONE, which holds until the output register is free to take the result.
// One item is in work at a time; the key memory serves one probe per cycle and the next
// transfer can follow in the cycle after the result is loaded; a new item is taken while a
// result waits in the output register.
// Reset clears control state and makes every group count read as zero; the key table is not cleared.
`default_nettype none

module grouped_sorted_key_search_unit #(
  parameter int unsigned GROUP_COUNT       = gsks_pkg::GROUP_COUNT_DEF,
  parameter int unsigned ENTRIES_PER_GROUP = gsks_pkg::ENTRIES_PER_GROUP_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire gsks_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output gsks_pkg::out_item_t      out_item_o
);
  import gsks_pkg::*;

  localparam int unsigned DEPTH = GROUP_COUNT * ENTRIES_PER_GROUP;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned GW    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CNT   = 4'b0010,
    S_PROBE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [KEY_W-1:0]   key_mem [DEPTH];
  logic [COUNT_W-1:0] cnt_mem [GROUP_COUNT];
  logic [GROUP_COUNT-1:0] cnt_vld_q;

  logic [KEY_W-1:0]   key_rdata_q;
  logic [COUNT_W-1:0] cnt_rdata_q;
  logic               cnt_hit_q;

  logic [KEY_W-1:0]   key_q, key_d;
  logic [AW-1:0]      base_q, base_d;
  logic signed [10:0] lo_q, lo_d, hi_q, hi_d;
  logic [COUNT_W-1:0] mid_q, mid_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  out_item_t          res_q, res_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               grp_ok;
  logic               key_in_ok;
  logic [GW-1:0]      gidx;
  logic [AW-1:0]      in_base;
  logic               key_we, key_re;
  logic [AW-1:0]      key_waddr, key_raddr;
  logic               cnt_we, cnt_re;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [COUNT_W-1:0] cnt_eff;
  logic signed [10:0] lo_n, hi_n, mid_sum;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign grp_ok     = 7'(in_item_i.group) < 7'(GROUP_COUNT);
  assign key_in_ok  = 17'(in_item_i.key) < 17'(KEY_LIMIT);
  assign gidx       = GW'(in_item_i.group);
  assign in_base    = AW'(AW'(gidx) * AW'(ENTRIES_PER_GROUP));
  assign key_waddr  = in_base + AW'(in_item_i.position);

  assign key_we = accept && grp_ok && (in_item_i.operation == OP_WRITE) && key_in_ok
                  && (13'(in_item_i.position) < 13'(ENTRIES_PER_GROUP));
  assign cnt_we = accept && grp_ok && (in_item_i.operation == OP_SET_COUNT);
  assign cnt_re = accept && grp_ok && (in_item_i.operation == OP_SEARCH);

  // saturate the new count at the table size
  always_comb begin
    cnt_wdata = in_item_i.entry_count;
    if (13'(in_item_i.entry_count) > 13'(ENTRIES_PER_GROUP)) begin
      cnt_wdata = COUNT_W'(ENTRIES_PER_GROUP);
    end
  end

  assign cnt_eff = cnt_hit_q ? cnt_rdata_q : '0;

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    base_d      = base_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    key_re      = 1'b0;
    key_raddr   = base_q + AW'(mid_q);
    lo_n        = lo_q;
    hi_n        = hi_q;
    mid_sum     = '0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d  = in_item_i.key;
          base_d = in_base;
          res_d  = '{status: ST_RANGE, match_position: '0};
          state_d = S_DONE;
          if (grp_ok) begin
            case (in_item_i.operation)
              OP_WRITE:     if (key_we) res_d.status = ST_WRITTEN;
              OP_SET_COUNT: res_d.status = ST_WRITTEN;
              OP_SEARCH:    state_d = S_CNT;
              default:      res_d.status = ST_RANGE;
            endcase
          end
        end
      end
      S_CNT: begin
        cnt_d = cnt_eff;
        lo_d  = '0;
        hi_d  = $signed({2'b00, cnt_eff}) - 11'sd1;
        mid_d = COUNT_W'(hi_d[10:1]);
        if (cnt_eff == '0 || 17'(key_q) >= 17'(KEY_LIMIT)) begin
          res_d   = '{status: ST_MISS, match_position: '0};
          state_d = S_DONE;
        end else begin
          key_re    = 1'b1;
          key_raddr = base_q + AW'(mid_d);
          state_d   = S_PROBE;
        end
      end
      S_PROBE: begin
        if (key_rdata_q == key_q) begin
          res_d   = '{status: ST_FOUND, match_position: POS_W'(mid_q)};
          state_d = S_DONE;
        end else begin
          // narrow the range toward the key
          if (key_rdata_q < key_q) begin
            lo_n = $signed({2'b00, mid_q}) + 11'sd1;
          end else begin
            hi_n = $signed({2'b00, mid_q}) - 11'sd1;
          end
          lo_d    = lo_n;
          hi_d    = hi_n;
          mid_sum = lo_n + hi_n;
          mid_d   = COUNT_W'(mid_sum[10:1]);
          if (lo_n <= hi_n) begin
            key_re    = 1'b1;
            key_raddr = base_q + AW'(mid_d);
          end else begin
            res_d   = '{status: ST_MISS, match_position: '0};
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[key_waddr] <= in_item_i.key;
    end
    if (key_re) begin
      key_rdata_q <= key_mem[key_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[gidx] <= cnt_wdata;
    end
    if (cnt_re) begin
      cnt_rdata_q <= cnt_mem[gidx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_vld_q <= '0;
      cnt_hit_q <= 1'b0;
    end else begin
      if (cnt_we) begin
        cnt_vld_q[gidx] <= 1'b1;
      end
      if (cnt_re) begin
        cnt_hit_q <= cnt_vld_q[gidx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    base_q <= base_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    cnt_q  <= cnt_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_no_mem_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(key_we && key_re))
    else $error("key memory read and write in the same cycle");

  a_probe_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q <= hi_q) && (hi_q < $signed({2'b00, cnt_q})))
    else $error("probe outside the live search range");

  a_miss_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status != ST_FOUND)) |-> (out_item_o.match_position == '0))
    else $error("nonzero match position on a non-found result");

  a_done_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DONE) && !out_stall_i) |=> (out_valid_o && (state_q == S_IDLE)))
    else $error("finished result not moved to the output register");

  a_probe_follows_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> $past(key_re))
    else $error("probe compare without a memory read in the prior cycle");

endmodule

`default_nettype wire

@@ verif/tb_grouped_sorted_key_search_unit.sv @@
// Self-checking testbench for the grouped sorted key search unit.
module tb_grouped_sorted_key_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import gsks_pkg::*;

  localparam logic [1:0]  OP_UNKNOWN      = 2'd3;
  localparam int unsigned ITEM_TARGET     = 1100;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES    = 24;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    in_item_t  stim;
    logic      fixed;   // expectation given in the row, not by the lookup model
    out_item_t want;
  } directed_row_t;

  // operation, group, position, key, entry_count | fixed, status, match_position
  localparam directed_row_t DIRECTED_ROWS [24] = '{
    {OP_SEARCH,    3'd0, 8'd0,   12'd0,    9'd0,     1'b1, ST_MISS,    8'd0},
    {OP_SEARCH,    3'd7, 8'hFF,  12'hFFF,  9'h1FF,   1'b1, ST_MISS,    8'd0},
    {OP_UNKNOWN,   3'd0, 8'd0,   12'd0,    9'd0,     1'b1, ST_RANGE,   8'd0},
    {OP_UNKNOWN,   3'd7, 8'hFF,  12'hFFF,  9'h1FF,   1'b1, ST_RANGE,   8'd0},
    {OP_WRITE,     3'd0, 8'd0,   12'd0,    9'h1FF,   1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd0, 8'd1,   12'hFFF,  9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd0, 8'hFF,  12'hABC,  9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd7, 8'hFF,  12'hFFF,  9'h1FF,   1'b1, ST_WRITTEN, 8'd0},
    {OP_SET_COUNT, 3'd0, 8'hFF,  12'hFFF,  9'd1,     1'b1, ST_WRITTEN, 8'd0},
    {OP_SEARCH,    3'd0, 8'hFF,  12'd0,    9'h1FF,   1'b1, ST_FOUND,   8'd0},
    {OP_SEARCH,    3'd0, 8'd0,   12'hFFF,  9'd0,     1'b1, ST_MISS,    8'd0},
    {OP_SET_COUNT, 3'd0, 8'd0,   12'd0,    9'd2,     1'b1, ST_WRITTEN, 8'd0},
    {OP_SEARCH,    3'd0, 8'd0,   12'hFFF,  9'd0,     1'b1, ST_FOUND,   8'd1},
    {OP_SEARCH,    3'd0, 8'd0,   12'd0,    9'd0,     1'b1, ST_FOUND,   8'd0},
    {OP_SEARCH,    3'd0, 8'd0,   12'd5,    9'd0,     1'b0, ST_FOUND,   8'd0},
    {OP_SET_COUNT, 3'd7, 8'd0,   12'd0,    9'h1FF,   1'b1, ST_WRITTEN, 8'd0},
    {OP_SET_COUNT, 3'd7, 8'd0,   12'd0,    9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd1, 8'd0,   12'd500,  9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd1, 8'd1,   12'd100,  9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_WRITE,     3'd1, 8'd2,   12'd300,  9'd0,     1'b1, ST_WRITTEN, 8'd0},
    {OP_SET_COUNT, 3'd1, 8'd0,   12'd0,    9'd3,     1'b1, ST_WRITTEN, 8'd0},
    {OP_SEARCH,    3'd1, 8'd0,   12'd100,  9'd0,     1'b0, ST_FOUND,   8'd0},
    {OP_SEARCH,    3'd1, 8'd0,   12'd500,  9'd0,     1'b0, ST_FOUND,   8'd0},
    {OP_SEARCH,    3'd1, 8'd0,   12'd300,  9'd0,     1'b0, ST_FOUND,   8'd0}
  };

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  // Lookup model state
  logic [KEY_W-1:0]   key_store   [GROUP_COUNT_DEF][ENTRIES_PER_GROUP_DEF];
  bit                 key_written [GROUP_COUNT_DEF][ENTRIES_PER_GROUP_DEF];
  logic [COUNT_W-1:0] group_len   [GROUP_COUNT_DEF];

  out_item_t   expected_results[$];
  int unsigned mismatches   = 0;
  int unsigned items_sent   = 0;
  int unsigned gapless_left = 0;
  bit          hold_off_req = 1'b0;

  grouped_sorted_key_search_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int g = 0; g < GROUP_COUNT_DEF; g++) begin
      group_len[g] = '0;
      for (int p = 0; p < ENTRIES_PER_GROUP_DEF; p++) begin
        key_store[g][p]   = '0;
        key_written[g][p] = 1'b0;
      end
    end
  end

  // Halving search over [0, count-1]; also flags a probe of a never-written entry.
  function automatic logic [1:0] search_table(input logic [GROUP_W-1:0] g,
                                              input logic [KEY_W-1:0] k,
                                              output logic [POS_W-1:0] pos,
                                              output bit reads_blank);
    int lo, hi, mid;
    lo = 0;
    hi = int'(group_len[g]) - 1;
    pos = '0;
    reads_blank = 1'b0;
    if (int'(k) >= KEY_LIMIT) return ST_MISS;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (!key_written[g][mid]) reads_blank = 1'b1;
      if (key_store[g][mid] == k) begin
        pos = mid[POS_W-1:0];
        return ST_FOUND;
      end
      if (key_store[g][mid] < k) lo = mid + 1;
      else hi = mid - 1;
    end
    return ST_MISS;
  endfunction

  function automatic out_item_t apply_item(input in_item_t it);
    out_item_t        r;
    logic [POS_W-1:0] pos;
    bit               blank;
    r.status = ST_RANGE;
    r.match_position = '0;
    if (int'(it.group) < GROUP_COUNT_DEF) begin
      case (it.operation)
        OP_WRITE: begin
          key_store[it.group][it.position]   = it.key;
          key_written[it.group][it.position] = 1'b1;
          r.status = ST_WRITTEN;
        end
        OP_SET_COUNT: begin
          // saturate at the table size
          group_len[it.group] = (it.entry_count > ENTRIES_PER_GROUP_DEF) ?
                                COUNT_W'(ENTRIES_PER_GROUP_DEF) : it.entry_count;
          r.status = ST_WRITTEN;
        end
        OP_SEARCH: begin
          r.status = search_table(it.group, it.key, pos, blank);
          r.match_position = pos;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.operation   = 2'($urandom);
    it.group       = GROUP_W'($urandom);
    it.position    = POS_W'($urandom);
    it.key         = KEY_W'($urandom);
    it.entry_count = COUNT_W'($urandom);
    return it;
  endfunction

  // Called at a rising edge; returns at the edge where the transfer happened.
  task automatic transfer_item(input in_item_t it, input bit fixed, input out_item_t want);
    out_item_t   predicted;
    int unsigned gap;
    gap = (gapless_left > 0 || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gapless_left > 0) gapless_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    predicted = apply_item(it);
    expected_results.push_back(fixed ? want : predicted);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  // Fill a group with ascending keys, set its count, then search for some of them, keys just above them or random keys.
  task automatic sorted_run();
    in_item_t           it;
    int unsigned        n, span;
    logic [GROUP_W-1:0] g;
    g = GROUP_W'($urandom);
    n = ($urandom_range(0, 39) == 0) ? ENTRIES_PER_GROUP_DEF : $urandom_range(1, 12);
    span = KEY_LIMIT / n;
    for (int i = 0; i < n; i++) begin
      it = random_item();
      it.operation = OP_WRITE;
      it.group     = g;
      it.position  = POS_W'(i);
      it.key       = KEY_W'(i * span + $urandom_range(0, span - 1));
      transfer_item(it, 1'b0, '0);
    end
    it = random_item();
    it.operation   = OP_SET_COUNT;
    it.group       = g;
    it.entry_count = (n == ENTRIES_PER_GROUP_DEF) ? COUNT_W'($urandom_range(256, 511))
                                                  : COUNT_W'(n);
    transfer_item(it, 1'b0, '0);
    repeat ($urandom_range(2, 8)) begin
      it = random_item();
      it.operation = OP_SEARCH;
      it.group     = g;
      case ($urandom_range(0, 2))
        0: it.key = key_store[g][$urandom_range(0, n - 1)];
        1: it.key = key_store[g][$urandom_range(0, n - 1)] + 1'b1;
        default: ;
      endcase
      transfer_item(it, 1'b0, '0);
    end
  endtask

  task automatic noise_item();
    in_item_t         it;
    logic [POS_W-1:0] pos;
    logic [1:0]       st;
    bit               blank;
    it = random_item();
    if (it.operation == OP_SEARCH) begin
      st = search_table(it.group, it.key, pos, blank);
      // drop searches that would probe a never-written entry
      if (blank) return;
    end
    transfer_item(it, 1'b0, '0);
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch, %s: expected status %0d position %0d, got status %0d position %0d",
               what, want.status, want.match_position, got.status, got.match_position);
  endtask

  always @(posedge clk_i) begin : result_check
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", '0, out_item_o);
      end else begin
        want = expected_results.pop_front();
        if (out_item_o.status !== want.status)
          report_mismatch("status", want, out_item_o);
        if (out_item_o.match_position !== want.match_position)
          report_mismatch("match_position", want, out_item_o);
      end
    end
  end

  initial begin : receiver_pace
    int unsigned stall_left, ready_left;
    stall_left = 0;
    ready_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall_left = HOLD_OFF_CYCLES;
        ready_left = 0;
      end else if (stall_left == 0 && ready_left == 0) begin
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : pick_gap();
        ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 20);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        ready_left--;
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    bit pressure_done, pause_done;
    pressure_done = 1'b0;
    pause_done    = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < $size(DIRECTED_ROWS); i++)
      transfer_item(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].want);
    wait_idle();
    while (items_sent < ITEM_TARGET) begin
      if (!pressure_done && items_sent > 350) begin
        // keep offering back to back while the output is held off
        hold_off_req  = 1'b1;
        gapless_left  = 12;
        pressure_done = 1'b1;
      end
      if (!pause_done && items_sent > 700) begin
        wait_idle();
        pause_done = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) gapless_left = $urandom_range(20, 60);
      if ($urandom_range(0, 9) < 7) sorted_run();
      else noise_item();
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
